FILE: design/ima_enc_pkg.sv
package ima_enc_pkg;

    localparam logic [6:0] MaxStepPos = 7'd88;

    localparam logic signed [17:0] PcmMax = 18'sd32767;
    localparam logic signed [17:0] PcmMin = -18'sd32768;

    typedef struct packed {
        logic [3:0]         code;
        logic signed [15:0] pred;
        logic [6:0]         idx;
    } t_enc_result;

    // standard 89-entry step size table
    function automatic logic [14:0] step_size(input logic [6:0] pos);
        logic [14:0] s;
        begin
            case (pos)
                7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
                7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
                7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
                7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
                7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
                7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
                7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
                7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
                7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
                7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
                7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
                7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
                7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
                7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
                7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
                7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
                7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
                7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
                7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
                7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
                7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
                7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
                7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
                7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
                7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
                7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
                7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
                7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
                7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
                7'd87: s = 15'd29794;
                default: s = 15'd32767;
            endcase
            return s;
        end
    endfunction

    // index adjustment chosen by the magnitude bits of the code
    function automatic logic signed [4:0] index_move(input logic [2:0] mag);
        logic signed [4:0] m;
        begin
            case (mag)
                3'd4:    m = 5'sd2;
                3'd5:    m = 5'sd4;
                3'd6:    m = 5'sd6;
                3'd7:    m = 5'sd8;
                default: m = -5'sd1;
            endcase
            return m;
        end
    endfunction

endpackage

FILE: design/ima_enc_step.sv
module ima_enc_step (
    input  logic signed [15:0]      i_sample,
    input  logic signed [15:0]      i_pred,
    input  logic [6:0]              i_idx,
    output ima_enc_pkg::t_enc_result o_res
);

    always_comb begin
        logic [6:0]         pos;
        logic [14:0]        step;
        logic signed [16:0] diff;
        logic               neg;
        logic [16:0]        mag;
        logic [16:0]        rem;
        logic [16:0]        vp;
        logic [2:0]         bits;
        logic signed [17:0] np;
        logic signed [4:0]  mv;
        logic signed [7:0]  ni;

        pos  = (i_idx > ima_enc_pkg::MaxStepPos) ? ima_enc_pkg::MaxStepPos : i_idx;
        step = ima_enc_pkg::step_size(pos);
        diff = {i_sample[15], i_sample} - {i_pred[15], i_pred};
        neg  = diff[16];
        mag  = neg ? 17'(-diff) : 17'(diff);

        // three successive-approximation compares against step, step/2, step/4
        rem = mag;
        vp  = {5'd0, step[14:3]};
        bits[2] = (rem >= {2'd0, step});
        if (bits[2]) begin
            rem = rem - {2'd0, step};
            vp  = vp + {2'd0, step};
        end
        bits[1] = (rem >= {3'd0, step[14:1]});
        if (bits[1]) begin
            rem = rem - {3'd0, step[14:1]};
            vp  = vp + {3'd0, step[14:1]};
        end
        bits[0] = (rem >= {4'd0, step[14:2]});
        if (bits[0]) begin
            vp = vp + {4'd0, step[14:2]};
        end

        np = neg ? ({{2{i_pred[15]}}, i_pred} - $signed({1'b0, vp}))
                 : ({{2{i_pred[15]}}, i_pred} + $signed({1'b0, vp}));
        if (np > ima_enc_pkg::PcmMax) begin
            o_res.pred = 16'sh7FFF;
        end else if (np < ima_enc_pkg::PcmMin) begin
            o_res.pred = 16'sh8000;
        end else begin
            o_res.pred = np[15:0];
        end

        mv = ima_enc_pkg::index_move(bits);
        ni = $signed({1'b0, pos}) + {{3{mv[4]}}, mv};
        if (ni[7]) begin
            o_res.idx = 7'd0;
        end else if (ni[6:0] > ima_enc_pkg::MaxStepPos) begin
            o_res.idx = ima_enc_pkg::MaxStepPos;
        end else begin
            o_res.idx = ni[6:0];
        end

        o_res.code = {neg, bits};
    end

endmodule

FILE: design/ima_adpcm_encoder_core.sv
// IMA ADPCM 4-bit encoder. Each input beat carries one signed 16-bit sample; the
// block keeps the predictor and step index and packs two codes per output byte,
// earlier code in the low nibble. Samples land in an input register, are encoded
// from there by a single encoder (step table lookup, three compares, predictor
// and index update) and the byte goes to an output register, so a beat is taken
// every cycle while the output is free. The one exception is a first-nibble beat
// with end_of_block set: the zero-sample pad then occupies the shared encoder, so
// the next beat waits. With the output free, the beat completing a byte passes the
// input register and then the output register (a padded byte also the pad state).
module ima_adpcm_encoder_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_sample,
    input  logic               i_restart,
    input  logic               i_end_of_block,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_packed_byte
);

    logic               r_in_vld, n_in_vld;
    logic signed [15:0] r_sample;
    logic               r_restart;
    logic               r_eob;

    logic signed [15:0] r_pred, n_pred;
    logic [6:0]         r_idx, n_idx;
    logic               r_phase, n_phase;
    logic [3:0]         r_held, n_held;
    logic               r_pad, n_pad;

    logic               r_out_vld, n_out_vld;
    logic [7:0]         r_out_byte, n_out_byte;

    logic               out_free;
    logic               phase_eff;
    logic               consume;
    logic               fire_pad;
    logic               in_ready;
    logic signed [15:0] enc_sample;
    logic signed [15:0] enc_pred;
    logic [6:0]         enc_idx;

    ima_enc_pkg::t_enc_result enc_res;

    ima_enc_step u_step (
        .i_sample (enc_sample),
        .i_pred   (enc_pred),
        .i_idx    (enc_idx),
        .o_res    (enc_res)
    );

    always_comb begin
        out_free  = !r_out_vld || i_out_ready;
        phase_eff = r_restart ? 1'b0 : r_phase;
        fire_pad  = r_pad && out_free;
        consume   = !r_pad && r_in_vld && (!phase_eff || out_free);
        in_ready  = !r_in_vld || consume;

        // the pad encodes a zero sample from the live state, never restarted
        enc_sample = r_pad ? 16'sd0 : r_sample;
        enc_pred   = (!r_pad && r_restart) ? 16'sd0 : r_pred;
        enc_idx    = (!r_pad && r_restart) ? 7'd0 : r_idx;

        n_in_vld   = in_ready ? i_in_valid : r_in_vld;
        n_pred     = r_pred;
        n_idx      = r_idx;
        n_phase    = r_phase;
        n_held     = r_held;
        n_pad      = r_pad;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out_byte = r_out_byte;

        if (fire_pad) begin
            n_pred     = enc_res.pred;
            n_idx      = enc_res.idx;
            n_pad      = 1'b0;
            n_out_vld  = 1'b1;
            n_out_byte = {enc_res.code, r_held};
        end else if (consume) begin
            n_pred = enc_res.pred;
            n_idx  = enc_res.idx;
            if (!phase_eff) begin
                n_held  = enc_res.code;
                n_phase = !r_eob;
                n_pad   = r_eob;
            end else begin
                n_phase    = 1'b0;
                n_out_vld  = 1'b1;
                n_out_byte = {enc_res.code, r_held};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_pred    <= 16'sd0;
            r_idx     <= 7'd0;
            r_phase   <= 1'b0;
            r_held    <= 4'd0;
            r_pad     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_pred    <= n_pred;
            r_idx     <= n_idx;
            r_phase   <= n_phase;
            r_held    <= n_held;
            r_pad     <= n_pad;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_sample  <= i_sample;
            r_restart <= i_restart;
            r_eob     <= i_end_of_block;
        end
        r_out_byte <= n_out_byte;
    end

    assign o_in_ready    = in_ready;
    assign o_out_valid   = r_out_vld;
    assign o_packed_byte = r_out_byte;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= ima_enc_pkg::MaxStepPos)
        else $error("step index out of range");

    a_pad_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad |-> !r_phase)
        else $error("pad pending while waiting for high nibble");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_pad || r_in_vld))
        else $error("output byte without an encode");

    a_pad_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pad && r_in_vld) |-> !o_in_ready)
        else $error("input taken while pad pending");

endmodule
